[hw/rtl/ipd_pkg.sv]
// Shared types, constants and helper functions of the +IPD header parser.
`timescale 1ns / 1ps

package ipd_pkg;

    localparam int LEN_WIDTH = 16;
    localparam int PREFIX_LEN = 5;
    localparam int MAX_LINK_ID = 4;

    localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [15:0] CAPTURE_LIMIT_RESET  = 16'd1024;
    localparam logic [15:0] HEADER_TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] DATA_TIMEOUT_RESET   = 16'd3000;

    typedef enum logic [1:0] {
        CFG_CAPTURE_LIMIT  = 2'd0,
        CFG_HEADER_TIMEOUT = 2'd1,
        CFG_DATA_TIMEOUT   = 2'd2,
        CFG_UNUSED         = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_PAYLOAD        = 3'd0,
        ST_BAD_ID         = 3'd1,
        ST_BAD_LENGTH     = 3'd2,
        ST_HEADER_TIMEOUT = 3'd3,
        ST_DATA_TIMEOUT   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_HEAD = 3'b010,
        PH_DATA = 3'b100
    } phase_t;

    typedef enum logic {
        FUNC_BYTE = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef struct packed {
        logic [15:0] capture_limit;
        logic [15:0] header_timeout;
        logic [15:0] data_timeout;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic [2:0]  link_id;
        logic        has_link_id;
        logic [15:0] announced_len;
        logic        last;
    } res_t;

    // Character expected at each position of the "+IPD," prefix.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = CHAR_PLUS;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h44;
            3'd4:    c = CHAR_COMMA;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // One decimal digit appended to a number, saturating at the all-ones value.
    function automatic logic [LEN_WIDTH-1:0] add_digit(input logic [LEN_WIDTH-1:0] n,
                                                       input logic [3:0] d);
        logic [LEN_WIDTH+3:0] v;
        v = ({4'd0, n} << 3) + ({4'd0, n} << 1) + {{LEN_WIDTH{1'b0}}, d};
        return (v > {4'd0, LEN_MAX}) ? LEN_MAX : v[LEN_WIDTH-1:0];
    endfunction

endpackage

[hw/rtl/ipd_rx_if.sv]
// Input channel: one received byte or one millisecond tick per transfer.
`timescale 1ns / 1ps

interface ipd_rx_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink (input valid, input func, input rx_byte, output ready);
endinterface

[hw/rtl/ipd_res_if.sv]
// Result channel: payload bytes and error reports of the header parser.
`timescale 1ns / 1ps

interface ipd_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic [2:0]  link_id;
    logic        has_link_id;
    logic [15:0] announced_len;
    logic        last;

    modport source (output valid, output status, output payload_byte, output link_id,
                    output has_link_id, output announced_len, output last, input ready);
    modport sink (input valid, input status, input payload_byte, input link_id,
                  input has_link_id, input announced_len, input last, output ready);
endinterface

[hw/rtl/ipd_packet_header_parser_top.sv]
// Top level of the +IPD receive header parser: configuration registers, input register, parser, result register.
`timescale 1ns / 1ps

// The block takes one item per clock cycle, a received byte or a millisecond
// tick, while no waiting result holds the flow, and gives at most one result
// for it. An accepted item sits in the input register until it moves on; at
// that edge the parser updates its state and loads the result register, which
// then offers the result to the sink. The result register holds a result
// while the sink stalls, and the input side keeps taking items as long as
// they cause no result or the result register can be refilled. Configuration
// writes take effect at once and are meant to be made while no item is in
// flight.
module ipd_packet_header_parser_top
    import ipd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ipd_rx_if.sink      rx_ch,
    ipd_res_if.source   res_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t       cfg;
    logic       in_valid_reg;
    logic       in_func_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;
    logic       produces;
    res_t       res;
    logic       advance;

    ipd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (advance),
        .func     (in_func_reg),
        .rx_byte  (in_byte_reg),
        .cfg      (cfg),
        .produces (produces),
        .res      (res)
    );

    // An item moves on unless its result would overwrite one still waiting.
    assign advance     = in_valid_reg && (!produces || !out_valid_reg || res_ch.ready);
    assign rx_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx_ch.valid && rx_ch.ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rx_ch.valid && rx_ch.ready)
        begin
            in_func_reg <= rx_ch.func;
            in_byte_reg <= rx_ch.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && produces)
            out_valid_reg <= 1'b1;
        else if (res_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && produces)
            out_res_reg <= res;
    end

    assign res_ch.valid         = out_valid_reg;
    assign res_ch.status        = out_res_reg.status;
    assign res_ch.payload_byte  = out_res_reg.payload_byte;
    assign res_ch.link_id       = out_res_reg.link_id;
    assign res_ch.has_link_id   = out_res_reg.has_link_id;
    assign res_ch.announced_len = out_res_reg.announced_len;
    assign res_ch.last          = out_res_reg.last;

endmodule

[hw/rtl/ipd_cfg_regs.sv]
// Configuration registers of the header parser.
`timescale 1ns / 1ps

module ipd_cfg_regs
    import ipd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capture_limit  <= CAPTURE_LIMIT_RESET;
            cfg_reg.header_timeout <= HEADER_TIMEOUT_RESET;
            cfg_reg.data_timeout   <= DATA_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CAPTURE_LIMIT:  cfg_reg.capture_limit  <= cfg_data;
                CFG_HEADER_TIMEOUT: cfg_reg.header_timeout <= cfg_data;
                CFG_DATA_TIMEOUT:   cfg_reg.data_timeout   <= cfg_data;
                CFG_UNUSED:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/ipd_parser.sv]
// Parser state and the per-item update: prefix hunt, header digits, payload and timeouts.
`timescale 1ns / 1ps

module ipd_parser
    import ipd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic       func,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       produces,
    output res_t       res
);

    phase_t               phase_reg, phase_next;
    logic [2:0]           prefix_reg, prefix_next;
    logic [LEN_WIDTH-1:0] first_reg, first_next;
    logic [LEN_WIDTH-1:0] second_reg, second_next;
    logic                 comma_reg, comma_next;
    logic                 stopped_reg, stopped_next;
    logic [15:0]          taken_reg, taken_next;
    logic [15:0]          wanted_reg, wanted_next;
    logic [15:0]          ticks_reg, ticks_next;
    logic [2:0]           id_reg, id_next;
    logic                 has_id_reg, has_id_next;
    logic [LEN_WIDTH-1:0] len_reg, len_next;

    logic                 is_digit;
    logic [3:0]           digit;
    logic [15:0]          ticks_inc;
    logic [15:0]          taken_inc;
    logic [15:0]          limit;
    logic [LEN_WIDTH-1:0] len_sel;
    logic [2:0]           prefix_inc;
    logic                 to_hunt;

    assign is_digit   = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign digit      = 4'(rx_byte - CHAR_ZERO);
    assign ticks_inc  = (ticks_reg != 16'hFFFF) ? ticks_reg + 16'd1 : ticks_reg;
    assign taken_inc  = taken_reg + 16'd1;
    assign limit      = (cfg.capture_limit == 16'd0) ? 16'd1 : cfg.capture_limit;
    assign len_sel    = comma_reg ? second_reg : first_reg;
    assign prefix_inc = prefix_reg + 3'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        prefix_next  = prefix_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        comma_next   = comma_reg;
        stopped_next = stopped_reg;
        taken_next   = taken_reg;
        wanted_next  = wanted_reg;
        ticks_next   = ticks_reg;
        id_next      = id_reg;
        has_id_next  = has_id_reg;
        len_next     = len_reg;
        to_hunt      = 1'b0;
        produces     = 1'b0;
        res          = '0;

        if (func == FUNC_TICK)
        begin
            ticks_next = ticks_inc;
            if (phase_reg == PH_DATA)
            begin
                if (ticks_inc >= cfg.data_timeout)
                begin
                    to_hunt    = 1'b1;
                    produces   = 1'b1;
                    res.status = ST_DATA_TIMEOUT;
                end
            end
            else if (ticks_inc >= cfg.header_timeout)
            begin
                to_hunt    = 1'b1;
                produces   = 1'b1;
                res.status = ST_HEADER_TIMEOUT;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_DATA:
                begin
                    taken_next        = taken_inc;
                    produces          = 1'b1;
                    res.status        = ST_PAYLOAD;
                    res.payload_byte  = rx_byte;
                    res.link_id       = id_reg;
                    res.has_link_id   = has_id_reg;
                    res.announced_len = 16'(len_reg);
                    res.last          = taken_inc >= wanted_reg;
                    to_hunt           = res.last;
                end
                PH_HEAD:
                begin
                    priority if (is_digit)
                    begin
                        if (!stopped_reg)
                        begin
                            if (comma_reg)
                                second_next = add_digit(second_reg, digit);
                            else
                                first_next = add_digit(first_reg, digit);
                        end
                    end
                    else if (rx_byte == CHAR_COMMA && !comma_reg)
                    begin
                        comma_next   = 1'b1;
                        stopped_next = 1'b0;
                    end
                    else if (rx_byte != CHAR_COLON)
                    begin
                        stopped_next = 1'b1;
                    end
                    else if (comma_reg && first_reg > LEN_WIDTH'(MAX_LINK_ID))
                    begin
                        to_hunt    = 1'b1;
                        produces   = 1'b1;
                        res.status = ST_BAD_ID;
                    end
                    else
                    begin
                        id_next     = comma_reg ? 3'(first_reg) : 3'd0;
                        has_id_next = comma_reg;
                        len_next    = len_sel;
                        if (len_sel == '0)
                        begin
                            to_hunt    = 1'b1;
                            produces   = 1'b1;
                            res.status = ST_BAD_LENGTH;
                        end
                        else
                        begin
                            wanted_next = (32'(len_sel) < 32'(limit)) ? 16'(len_sel) : limit;
                            taken_next  = '0;
                            ticks_next  = '0;
                            phase_next  = PH_DATA;
                        end
                    end
                end
                default:
                begin
                    // Hunting: a mismatch may itself start a new prefix.
                    if (rx_byte == prefix_char(prefix_reg))
                        prefix_next = prefix_inc;
                    else
                        prefix_next = (rx_byte == CHAR_PLUS) ? 3'd1 : 3'd0;
                    if (rx_byte == prefix_char(prefix_reg) && 32'(prefix_inc) >= PREFIX_LEN)
                    begin
                        prefix_next  = '0;
                        phase_next   = PH_HEAD;
                        first_next   = '0;
                        second_next  = '0;
                        comma_next   = 1'b0;
                        stopped_next = 1'b0;
                    end
                end
            endcase
        end

        if (to_hunt)
        begin
            phase_next   = PH_HUNT;
            prefix_next  = '0;
            first_next   = '0;
            second_next  = '0;
            comma_next   = 1'b0;
            stopped_next = 1'b0;
            taken_next   = '0;
            wanted_next  = '0;
            ticks_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            prefix_reg  <= '0;
            first_reg   <= '0;
            second_reg  <= '0;
            comma_reg   <= 1'b0;
            stopped_reg <= 1'b0;
            taken_reg   <= '0;
            wanted_reg  <= '0;
            ticks_reg   <= '0;
            id_reg      <= '0;
            has_id_reg  <= 1'b0;
            len_reg     <= '0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            prefix_reg  <= prefix_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            comma_reg   <= comma_next;
            stopped_reg <= stopped_next;
            taken_reg   <= taken_next;
            wanted_reg  <= wanted_next;
            ticks_reg   <= ticks_next;
            id_reg      <= id_next;
            has_id_reg  <= has_id_next;
            len_reg     <= len_next;
        end
    end

endmodule
